### rtl/core/wildcard_byte_pattern_search_unit_macros.svh
// Assertion macros shared by the wildcard byte pattern search unit.
// Used by files under rtl/core; expects clk and rst_n in scope.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_UNIT_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, inactive while in reset
`define WBPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps assertion failed");

// Next-cycle implication, inactive while in reset
`define WBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps assertion failed");

`endif

### rtl/core/wbps_pkg.sv
// Package for the wildcard byte pattern search unit: widths, types, register codes.
// No dependencies; imported by the interfaces, the window cell and the top level.
package wbps_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int POS_W             = $clog2(MAX_PATTERN_BYTES);
    localparam int LEN_W             = POS_W + 1;
    localparam int CNT_W             = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int BYTES_PER_WORD    = 8;

    typedef logic [7:0]       byte_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH     = 3'd0,
        CFG_PATTERN_BYTES_LOW  = 3'd1,
        CFG_PATTERN_BYTES_HIGH = 3'd2,
        CFG_WILDCARD_MASK      = 3'd3
    } cfg_reg_t;

    // Pattern set-up broadcast to every window cell
    typedef struct packed {
        len_t                                eff_len;
        logic [MAX_PATTERN_BYTES-1:0][7:0]   pat;
        logic [MAX_PATTERN_BYTES-1:0]        wild;
    } scan_cfg_t;

    localparam cnt_t CNT_MAX = '1;

endpackage

### rtl/core/wbps_if.sv
// Stream interfaces for the wildcard byte pattern search unit (byte in, result out).
// Depends on wbps_pkg.
interface wbps_in_if;
    import wbps_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
    import wbps_pkg::*;

    logic valid;
    logic ready;
    logic found;
    cnt_t match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

### rtl/core/wbps_cell.sv
// One window cell: holds a byte of the search window, passes it on to the next
// cell on each shift and compares it with its pattern position. Depends on wbps_pkg.
module wbps_cell (
    input  logic                clk,
    input  logic                shift_en,
    input  wbps_pkg::byte_t     byte_in,
    input  wbps_pkg::pos_t      cell_idx,
    input  wbps_pkg::scan_cfg_t cfg,
    output wbps_pkg::byte_t     byte_out,
    output logic                hit
);
    import wbps_pkg::*;

    byte_t byte_reg;
    len_t  sel_full;
    pos_t  sel;
    logic  active;

    // Window byte, shifts towards older positions
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // Cell j lines up with pattern position len-1-j; cells past the length always hit
    always_comb
    begin
        active   = ({1'b0, cell_idx} < cfg.eff_len);
        sel_full = cfg.eff_len - {1'b0, cell_idx} - len_t'(1);
        sel      = sel_full[POS_W-1:0];
        hit      = !active || cfg.wild[sel] || (byte_reg == cfg.pat[sel]);
    end

endmodule

### rtl/core/wildcard_byte_pattern_search_unit.sv
// Top level of the wildcard byte pattern search unit.
// Depends on wbps_pkg, wbps_if, wbps_cell and the assertion macro header.
//
// Usage:
//   din carries one buffer byte per beat, last_byte marking the buffer's end.
//   dout gives one beat per buffer, on its last byte: found and the offset of
//   the first match start (0 when not found).
//   Configuration is written through cfg_we / cfg_index / cfg_data while idle;
//   index 0 pattern length, 1 and 2 the pattern bytes, 3 the wildcard mask.
// Throughput: one byte per cycle. The byte enters a row of 16 window cells at
//   acceptance; every cell then compares its byte in parallel in the compare
//   stage, and the match flag and offset are latched as the byte leaves it.
// Result path: the last byte is shifted into the window, then its compare
//   result is registered into the result register that drives dout.
// Stalls: the result register holds a finished beat while dout is stalled and
//   bytes of the next buffer keep flowing; only the next buffer's last byte
//   waits in the compare stage, and din.ready drops until dout frees.
// Reset: rst_n (asynchronous, active low) clears the configuration and control
//   registers, the byte count and the match latch; the window needs no clearing
//   as the byte count masks stale bytes.
`include "wildcard_byte_pattern_search_unit_macros.svh"

module wildcard_byte_pattern_search_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    wbps_in_if.sink                             din,
    wbps_out_if.source                          dout
);
    import wbps_pkg::*;

    // Configuration registers
    logic [4:0]                   pattern_length_reg;
    logic [CFG_DATA_W-1:0]        pattern_bytes_low_reg;
    logic [CFG_DATA_W-1:0]        pattern_bytes_high_reg;
    logic [MAX_PATTERN_BYTES-1:0] wildcard_mask_reg;

    scan_cfg_t scan_cfg;

    // Scan state
    cnt_t cnt_reg;
    cnt_t cnt_next;
    cnt_t cnt_base;
    logic restart_reg;
    logic eval_vld_reg;
    logic eval_last_reg;
    logic match_lat_reg;
    logic match_lat_next;
    cnt_t off_reg;
    cnt_t off_next;

    // Result register
    logic out_vld_reg;
    logic out_vld_next;
    logic out_found_reg;
    cnt_t out_off_reg;

    logic accept;
    logic out_free;
    logic eval_go;
    logic match_now;
    cnt_t cand_off;
    logic res_found;
    cnt_t res_off;

    logic [MAX_PATTERN_BYTES-1:0] hit_vec;
    byte_t                        win_byte [MAX_PATTERN_BYTES];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg     <= '0;
            pattern_bytes_low_reg  <= '0;
            pattern_bytes_high_reg <= '0;
            wildcard_mask_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[4:0];
                CFG_PATTERN_BYTES_LOW:  pattern_bytes_low_reg  <= cfg_data;
                CFG_PATTERN_BYTES_HIGH: pattern_bytes_high_reg <= cfg_data;
                CFG_WILDCARD_MASK:
                    wildcard_mask_reg <= cfg_data[MAX_PATTERN_BYTES-1:0];
                default: ;
            endcase
        end
    end

    // Pattern set-up for the cells; lengths above the window are clamped
    always_comb
    begin
        if (pattern_length_reg > 5'(MAX_PATTERN_BYTES))
        begin
            scan_cfg.eff_len = len_t'(MAX_PATTERN_BYTES);
        end
        else
        begin
            scan_cfg.eff_len = len_t'(pattern_length_reg);
        end
        for (int k = 0; k < BYTES_PER_WORD; k++)
        begin
            scan_cfg.pat[k]                  = pattern_bytes_low_reg[8*k +: 8];
            scan_cfg.pat[k + BYTES_PER_WORD] = pattern_bytes_high_reg[8*k +: 8];
        end
        scan_cfg.wild = wildcard_mask_reg;
    end

    // Handshake: compare stage stalls only on a last byte with the result full
    assign out_free  = !out_vld_reg || dout.ready;
    assign eval_go   = eval_vld_reg && (!eval_last_reg || out_free);
    assign din.ready = !eval_vld_reg || eval_go;
    assign accept    = din.valid && din.ready;

    // Window cells
    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++)
    begin : g_cell
        byte_t cell_in;
        if (j == 0)
        begin : g_head
            assign cell_in = din.data_byte;
        end
        else
        begin : g_body
            assign cell_in = win_byte[j-1];
        end

        wbps_cell u_cell (
            .clk      (clk),
            .shift_en (accept),
            .byte_in  (cell_in),
            .cell_idx (pos_t'(j)),
            .cfg      (scan_cfg),
            .byte_out (win_byte[j]),
            .hit      (hit_vec[j])
        );
    end

    // Byte count, saturating, restarted by the first byte after a last byte
    always_comb
    begin
        cnt_base = restart_reg ? '0 : cnt_reg;
        cnt_next = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + cnt_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            restart_reg   <= 1'b0;
            eval_vld_reg  <= 1'b0;
            eval_last_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg       <= cnt_next;
                restart_reg   <= din.last_byte;
                eval_last_reg <= din.last_byte;
            end
            if (accept)
            begin
                eval_vld_reg <= 1'b1;
            end
            else if (eval_go)
            begin
                eval_vld_reg <= 1'b0;
            end
        end
    end

    // Compare stage: window match, first-match latch and result
    always_comb
    begin
        match_now = (&hit_vec) && (cnt_reg >= cnt_t'(scan_cfg.eff_len));
        cand_off  = (scan_cfg.eff_len == '0) ? '0 : cnt_reg - cnt_t'(scan_cfg.eff_len);
        res_found = match_lat_reg || match_now;
        if (match_lat_reg)
        begin
            res_off = off_reg;
        end
        else if (match_now)
        begin
            res_off = cand_off;
        end
        else
        begin
            res_off = '0;
        end

        match_lat_next = match_lat_reg;
        off_next       = off_reg;
        if (eval_go)
        begin
            if (eval_last_reg)
            begin
                match_lat_next = 1'b0;
                off_next       = '0;
            end
            else if (!match_lat_reg && match_now)
            begin
                match_lat_next = 1'b1;
                off_next       = cand_off;
            end
        end

        out_vld_next = out_vld_reg;
        if (eval_go && eval_last_reg)
        begin
            out_vld_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_lat_reg <= 1'b0;
            off_reg       <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            match_lat_reg <= match_lat_next;
            off_reg       <= off_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (eval_go && eval_last_reg)
        begin
            out_found_reg <= res_found;
            out_off_reg   <= res_off;
        end
    end

    assign dout.valid        = out_vld_reg;
    assign dout.found        = out_found_reg;
    assign dout.match_offset = out_off_reg;

    // Checks
    `WBPS_ASSERT_NOW(a_offset_zero_when_absent, dout.valid && !dout.found,
                     dout.match_offset == '0)
    `WBPS_ASSERT_NEXT(a_accept_loads_compare, accept, eval_vld_reg)
    `WBPS_ASSERT_NEXT(a_last_clears_latch, eval_go && eval_last_reg, !match_lat_reg)
    `WBPS_ASSERT_NOW(a_offset_within_count, match_lat_reg, off_reg <= cnt_reg)

endmodule

### tb/sv/wildcard_byte_pattern_search_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for wildcard_byte_pattern_search_unit: a directed table, then random buffers
// under three idling mixes, each result checked against an in-bench scan model or a table row.
// Depends on wbps_pkg, the wbps_in_if / wbps_out_if interfaces and the unit's RTL.
module wildcard_byte_pattern_search_unit_tb;
    import wbps_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BEATS   = 500;
    localparam int LONG_HOLD     = 240;
    localparam int MAX_BUF_BYTES = 96;

    // Register indexes with nothing behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic found;
        cnt_t offset;
    } search_result_t;

    typedef enum logic {ROW_CFG, ROW_DATA} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wdata;   // register value, or the byte in [7:0]
        logic [4:0]            reps;    // beats of the same byte
        logic                  last;    // last flag on the final beat of the row
        logic                  typed;   // result below is used instead of the model's
        search_result_t        want;
    } dir_row_t;

    localparam int DIR_N = 22;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // empty pattern straight after reset matches at offset 0
        '{ROW_DATA, '0, 64'h00, 5'd1, 1'b1, 1'b1, '{1'b1, 32'd0}},
        // single-byte pattern at the top byte value, lowest byte first
        '{ROW_CFG, CFG_PATTERN_LENGTH, 64'd1, 5'd0, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_CFG, CFG_PATTERN_BYTES_LOW, 64'hFF, 5'd0, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_DATA, '0, 64'h00, 5'd1, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_DATA, '0, 64'hFF, 5'd1, 1'b1, 1'b1, '{1'b1, 32'd1}},
        // two-byte pattern A5 3C; the unmapped write must not touch the length
        '{ROW_CFG, CFG_PATTERN_LENGTH, 64'd2, 5'd0, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_CFG, CFG_PATTERN_BYTES_LOW, 64'h3CA5, 5'd0, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_CFG, CFG_UNMAPPED_LO, 64'h00, 5'd0, 1'b0, 1'b0, '{1'b0, 32'd0}},
        // buffer shorter than the pattern
        '{ROW_DATA, '0, 64'hA5, 5'd1, 1'b1, 1'b1, '{1'b0, 32'd0}},
        // two matches, the first one is kept
        '{ROW_DATA, '0, 64'h11, 5'd1, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_DATA, '0, 64'hA5, 5'd1, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_DATA, '0, 64'h3C, 5'd1, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_DATA, '0, 64'hA5, 5'd1, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_DATA, '0, 64'h3C, 5'd1, 1'b1, 1'b1, '{1'b1, 32'd1}},
        // wildcard on the first position
        '{ROW_CFG, CFG_WILDCARD_MASK, 64'h0001, 5'd0, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_DATA, '0, 64'h77, 5'd1, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_DATA, '0, 64'h3C, 5'd1, 1'b1, 1'b1, '{1'b1, 32'd0}},
        // length above the maximum is clamped to 16, all positions wild
        '{ROW_CFG, CFG_PATTERN_LENGTH, 64'd31, 5'd0, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_CFG, CFG_PATTERN_BYTES_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0, 1'b0,
          '{1'b0, 32'd0}},
        '{ROW_CFG, CFG_WILDCARD_MASK, 64'hFFFF, 5'd0, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_DATA, '0, 64'hFF, 5'd15, 1'b0, 1'b0, '{1'b0, 32'd0}},
        '{ROW_DATA, '0, 64'h00, 5'd1, 1'b1, 1'b1, '{1'b1, 32'd0}}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wbps_in_if  din_bus ();
    wbps_out_if dout_bus ();

    wildcard_byte_pattern_search_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (din_bus),
        .dout      (dout_bus)
    );

    // Register copies and scan state of the model
    logic [4:0]                   len_reg;
    logic [63:0]                  pat_lo_reg;
    logic [63:0]                  pat_hi_reg;
    logic [MAX_PATTERN_BYTES-1:0] wild_reg;
    byte_t                        window [MAX_PATTERN_BYTES];   // entry 0 newest
    cnt_t                         seen_cnt;
    logic                         hit_latched;
    cnt_t                         hit_offset;

    search_result_t results_due [$];
    int             err_count = 0;
    int unsigned    cycle_count = 0;
    int unsigned    beats_total = 0;
    int             src_idle_pct = 0;
    int             sink_idle_pct = 0;
    logic           sink_hold = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic int unsigned eff_len();
        return (len_reg > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : len_reg;
    endfunction

    function automatic byte_t pat_byte_at(int unsigned pos);
        logic [127:0] pat;
        pat = {pat_hi_reg, pat_lo_reg};
        return pat[8*pos +: 8];
    endfunction

    function automatic void clear_scan();
        foreach (window[i])
            window[i] = 8'h00;
        seen_cnt    = '0;
        hit_latched = 1'b0;
        hit_offset  = '0;
    endfunction

    // Append an expected result in arrival order
    function automatic void note_result(input search_result_t r);
        results_due = {results_due, r};
    endfunction

    // One byte through the scan; a result only on the buffer's last byte
    function automatic void search_step(input byte_t b, input logic is_last,
                                        output logic has_r, output search_result_t r);
        int unsigned len;
        logic        hit;
        len = eff_len();
        for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--)
            window[i] = window[i - 1];
        window[0] = b;
        if (seen_cnt != CNT_MAX)
            seen_cnt++;
        if (!hit_latched && seen_cnt >= len)
        begin
            hit = 1'b1;
            for (int i = 0; i < len; i++)
                if (!wild_reg[i] && pat_byte_at(i) != window[len - 1 - i])
                    hit = 1'b0;
            if (hit)
            begin
                hit_latched = 1'b1;
                hit_offset  = (len == 0) ? '0 : seen_cnt - len;
            end
        end
        has_r    = is_last;
        r.found  = hit_latched;
        r.offset = hit_latched ? hit_offset : '0;
        if (is_last)
            clear_scan();
    endfunction

    // ---------------------------------------------------------------- drivers

    // Offer one beat, with a random gap first, and return at its acceptance edge
    task automatic send_beat(input byte_t b, input logic is_last);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            din_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        din_bus.valid     <= 1'b1;
        din_bus.data_byte <= b;
        din_bus.last_byte <= is_last;
        do
            @(posedge clk);
        while (!din_bus.ready);
        beats_total++;
    endtask

    // Stop offering and wait for every outstanding result, then let the pipe settle
    task automatic wait_drained();
        din_bus.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_PATTERN_LENGTH:     len_reg    = val[4:0];
            CFG_PATTERN_BYTES_LOW:  pat_lo_reg = val;
            CFG_PATTERN_BYTES_HIGH: pat_hi_reg = val;
            CFG_WILDCARD_MASK:      wild_reg   = val[MAX_PATTERN_BYTES-1:0];
            default: ;
        endcase
    endtask

    // New pattern set-up, leaning towards short patterns with extremes mixed in
    task automatic apply_random_setting();
        logic [4:0]                   len;
        logic [63:0]                  lo;
        logic [63:0]                  hi;
        logic [MAX_PATTERN_BYTES-1:0] wild;
        int                           pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = '0;
        else if (pick < 18)
            len = 5'(MAX_PATTERN_BYTES);
        else if (pick < 26)
            len = 5'($urandom_range(31, MAX_PATTERN_BYTES + 1));
        else if (pick < 80)
            len = 5'($urandom_range(1, 6));
        else
            len = 5'($urandom_range(7, MAX_PATTERN_BYTES));
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 6)
            lo = '0;
        else if (pick < 12)
            lo = '1;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            hi = '0;
        else if (pick < 12)
            hi = '1;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            wild = '0;
        else if (pick < 38)
            wild = '1;
        else if (pick < 75)
            wild = MAX_PATTERN_BYTES'($urandom & $urandom);
        else
            wild = MAX_PATTERN_BYTES'($urandom);
        write_reg(CFG_PATTERN_LENGTH, 64'(len));
        write_reg(CFG_PATTERN_BYTES_LOW, lo);
        write_reg(CFG_PATTERN_BYTES_HIGH, hi);
        write_reg(CFG_WILDCARD_MASK, 64'(wild));
        if ($urandom_range(0, 4) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_UNMAPPED_HI, CFG_UNMAPPED_LO)),
                      {$urandom, $urandom});
    endtask

    // One buffer: pattern planted, planted and spoilt, built from pattern bytes, or noise
    task automatic send_buffer();
        byte_t          stream_bytes [MAX_BUF_BYTES];
        int unsigned    n;
        int unsigned    len;
        int unsigned    start;
        int unsigned    pos;
        int unsigned    pick;
        logic           has_r;
        search_result_t r;
        len  = eff_len();
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_BUF_BYTES)
                                           : $urandom_range(1, 24);
        pick = $urandom_range(0, 99);
        for (int k = 0; k < n; k++)
            stream_bytes[k] = (pick < 20) ? pat_byte_at($urandom_range(0, MAX_PATTERN_BYTES - 1))
                                          : byte_t'($urandom);
        if (pick >= 20 && pick < 90 && len != 0 && len <= n)
        begin
            start = $urandom_range(0, n - len);
            for (int i = 0; i < len; i++)
                if (!wild_reg[i])
                    stream_bytes[start + i] = pat_byte_at(i);
            if (pick >= 75)
            begin
                pos = $urandom_range(0, len - 1);
                stream_bytes[start + pos] = stream_bytes[start + pos]
                                            ^ byte_t'($urandom_range(1, 255));
            end
        end
        for (int k = 0; k < n; k++)
        begin
            send_beat(stream_bytes[k], k == n - 1);
            search_step(stream_bytes[k], k == n - 1, has_r, r);
            if (has_r)
                note_result(r);
        end
    endtask

    // ---------------------------------------------------------------- result side

    // Ready with random idling, plus the long hold; each result beat checked in order
    always @(posedge clk)
    begin
        search_result_t want;
        if (!rst_n)
            dout_bus.ready <= 1'b0;
        else
        begin
            if (dout_bus.valid && dout_bus.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: result beat with none expected: found %0b offset %0d",
                             $time, dout_bus.found, dout_bus.match_offset);
                    err_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (dout_bus.found !== want.found)
                    begin
                        $display("%0t: found expected %0b, got %0b",
                                 $time, want.found, dout_bus.found);
                        err_count++;
                    end
                    if (dout_bus.match_offset !== want.offset)
                    begin
                        $display("%0t: match_offset expected %0d, got %0d",
                                 $time, want.offset, dout_bus.match_offset);
                        err_count++;
                    end
                end
            end
            dout_bus.ready <= !sink_hold && ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("wildcard_byte_pattern_search_unit_tb: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial
    begin
        logic           has_r;
        logic           is_last;
        search_result_t r;
        dir_row_t       row;
        int unsigned    phase_end;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        din_bus.valid     <= 1'b0;
        din_bus.data_byte <= '0;
        din_bus.last_byte <= 1'b0;
        len_reg    = '0;
        pat_lo_reg = '0;
        pat_hi_reg = '0;
        wild_reg   = '0;
        clear_scan();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling on the input side, receiver fully ready
        for (int i = 0; i < DIR_N; i++)
        begin
            row = DIR_ROWS[i];
            if (row.kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(row.idx, row.wdata);
            end
            else
            begin
                for (int k = 0; k < row.reps; k++)
                begin
                    is_last = row.last && (k == row.reps - 1);
                    send_beat(row.wdata[7:0], is_last);
                    search_step(row.wdata[7:0], is_last, has_r, r);
                    if (has_r)
                        note_result(row.typed ? row.want : r);
                end
            end
        end

        // Random buffers: receiver-heavy idling, then sender-heavy, then none
        for (int ph = 0; ph < 3; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    src_idle_pct = 30;
                    sink_idle_pct <= 63;
                end
                1:
                begin
                    src_idle_pct = 63;
                    sink_idle_pct <= 30;
                end
                default:
                begin
                    src_idle_pct = 0;
                    sink_idle_pct <= 0;
                end
            endcase
            apply_random_setting();
            // long receiver hold while the sender keeps pushing bytes
            if (ph == 2)
                fork
                    begin
                        sink_hold <= 1'b1;
                        repeat (LONG_HOLD) @(posedge clk);
                        sink_hold <= 1'b0;
                    end
                join_none
            phase_end = beats_total + PHASE_BEATS;
            while (beats_total < phase_end)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    wait_drained();
                    apply_random_setting();
                end
                send_buffer();
            end
        end

        wait_drained();
        if (err_count == 0)
            $display("wildcard_byte_pattern_search_unit_tb: clean");
        else
            $display("wildcard_byte_pattern_search_unit_tb: errors");
        $finish;
    end

endmodule
